// ----- rtl/imu_sample_correction_core_assert.svh -----
// Assertion macros shared by the checker of the sample correction core.
`ifndef IMU_SAMPLE_CORRECTION_CORE_ASSERT_SVH
`define IMU_SAMPLE_CORRECTION_CORE_ASSERT_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define IMUSC_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define IMUSC_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/imusc_pkg.sv -----
// Shared types and constants of the IMU sample correction core.
`timescale 1ns / 1ps
`default_nettype none

package imusc_pkg;

    // Default field widths.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Configuration port.
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int FLAG_W     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_BIAS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_ROW0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_ROW1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_ROW2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_FLAGS = 3'd6;

    // Register values after reset: zero biases, unit scales, identity matrix.
    localparam logic [CFG_DATA_W-1:0] RST_ACCEL_BIAS  = 48'h0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ACCEL_SCALE = 48'h4000_4000_4000;
    localparam logic [CFG_DATA_W-1:0] RST_GYRO_OFFSET = 48'h0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ALIGN_ROW0  = 48'h0000_0000_4000;
    localparam logic [CFG_DATA_W-1:0] RST_ALIGN_ROW1  = 48'h0000_4000_0000;
    localparam logic [CFG_DATA_W-1:0] RST_ALIGN_ROW2  = 48'h4000_0000_0000;
    localparam logic [FLAG_W-1:0]     RST_VALID_FLAGS = 4'h0;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 4;

    // Corrections that are switched on for one word (enable bits and valid flags).
    typedef struct packed {
        logic align;
        logic gyro_offset;
        logic accel_scale;
        logic accel_bias;
    } imusc_ctl_t;

    localparam int CTL_W = $bits(imusc_ctl_t);

endpackage

`default_nettype wire

// ----- rtl/imusc_front.sv -----
// Front end: accepts input words, decides the corrections and removes the biases.
`timescale 1ns / 1ps
`default_nettype none

module imusc_front import imusc_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int IN_DW = ((6 * SAMPLE_WIDTH + FLAG_W + 7) / 8) * 8,
    localparam int DW    = 6 * SAMPLE_WIDTH
) (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DW-1:0]      s_tdata,
    input  logic [CFG_DATA_W-1:0] accel_bias,
    input  logic [CFG_DATA_W-1:0] gyro_offset,
    input  logic [FLAG_W-1:0]     valid_flags,
    input  logic                  q_full,
    output logic                  q_push,
    output imusc_ctl_t            q_ctl,
    output logic [DW-1:0]         q_data
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int LW = (3 * W > CFG_DATA_W) ? 3 * W : CFG_DATA_W;

    logic [LW-1:0] abias_ext;
    logic [LW-1:0] gbias_ext;

    function automatic logic [W-1:0] sat_w(input logic [W+3:0] x);
        logic [4:0] hi_bits;
        hi_bits = x[W+3:W-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return x[W-1:0];
        end else if (x[W+3]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    assign abias_ext = LW'(accel_bias);
    assign gbias_ext = LW'(gyro_offset);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_ctl    = imusc_ctl_t'(s_tdata[DW +: FLAG_W] & valid_flags);

    always_comb begin
        logic [W-1:0] raw;
        logic [W-1:0] bias;
        logic [W:0]   diff;
        logic         on;
        for (int k = 0; k < 6; k++) begin
            raw = s_tdata[k*W +: W];
            if (k < 3) begin
                bias = abias_ext[k*W +: W];
                on   = q_ctl.accel_bias;
            end else begin
                bias = gbias_ext[(k-3)*W +: W];
                on   = q_ctl.gyro_offset;
            end
            diff = {raw[W-1], raw} - {bias[W-1], bias};
            q_data[k*W +: W] = on ? sat_w({{3{diff[W]}}, diff}) : raw;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/imusc_queue.sv -----
// Short word queue that decouples the front end from the correction pipeline.
`timescale 1ns / 1ps
`default_nettype none

module imusc_queue import imusc_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = Q_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = store_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/imusc_back.sv -----
// Back end: accelerometer scaling and matrix rotation in a four-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

module imusc_back import imusc_pkg::*; #(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int DW     = 6 * SAMPLE_WIDTH,
    localparam int OUT_DW = ((DW + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  imusc_ctl_t            q_ctl,
    input  logic [DW-1:0]         q_data,
    input  logic [CFG_DATA_W-1:0] accel_scale,
    input  logic [CFG_DATA_W-1:0] align_row0,
    input  logic [CFG_DATA_W-1:0] align_row1,
    input  logic [CFG_DATA_W-1:0] align_row2,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DW-1:0]     m_tdata
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = COEF_FRAC_BITS;
    localparam int CW  = F + 2;
    localparam int PW  = W + CW;
    localparam int SW  = PW + 2;
    localparam int LCW = (3 * CW > CFG_DATA_W) ? 3 * CW : CFG_DATA_W;
    localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

    logic [LCW-1:0]        scale_ext;
    logic [LCW-1:0]        row_ext [3];
    logic signed [CW-1:0]  scale_c [3];
    logic signed [CW-1:0]  row_c   [3][3];
    logic signed [W-1:0]   a_in    [3];
    logic signed [W-1:0]   g_in    [3];
    logic                  adv;

    // Stage A: accelerometer scale products.
    logic signed [PW-1:0]  a_p_reg  [3];
    logic signed [PW-1:0]  a_p_next [3];
    logic signed [W-1:0]   a_a_reg  [3];
    logic signed [W-1:0]   g_a_reg  [3];
    imusc_ctl_t            ctl_a_reg;
    logic                  vld_a_reg;

    // Stage B: scaled accelerometer.
    logic signed [W-1:0]   a_b_reg  [3];
    logic signed [W-1:0]   a_b_next [3];
    logic signed [W-1:0]   g_b_reg  [3];
    imusc_ctl_t            ctl_b_reg;
    logic                  vld_b_reg;

    // Stage C: rotation products, row i by column j.
    logic signed [PW-1:0]  ra_p_reg  [3][3];
    logic signed [PW-1:0]  ra_p_next [3][3];
    logic signed [PW-1:0]  rg_p_reg  [3][3];
    logic signed [PW-1:0]  rg_p_next [3][3];
    logic signed [W-1:0]   a_c_reg   [3];
    logic signed [W-1:0]   g_c_reg   [3];
    imusc_ctl_t            ctl_c_reg;
    logic                  vld_c_reg;

    // Stage D: output register.
    logic [DW-1:0]         out_data_reg, out_data_next;
    logic                  out_valid_reg;

    function automatic logic [W-1:0] sat_w(input logic [W+3:0] x);
        logic [4:0] hi_bits;
        hi_bits = x[W+3:W-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return x[W-1:0];
        end else if (x[W+3]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    // The whole pipeline moves together whenever the output register can take a word.
    assign adv      = !out_valid_reg || m_tready;
    assign q_ready  = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'(out_data_reg);

    assign scale_ext  = LCW'(accel_scale);
    assign row_ext[0] = LCW'(align_row0);
    assign row_ext[1] = LCW'(align_row1);
    assign row_ext[2] = LCW'(align_row2);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            scale_c[k] = scale_ext[k*CW +: CW];
            a_in[k]    = q_data[k*W +: W];
            g_in[k]    = q_data[(k+3)*W +: W];
            for (int j = 0; j < 3; j++) begin
                row_c[k][j] = row_ext[k][j*CW +: CW];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            a_p_next[k] = PW'(a_in[k]) * PW'(scale_c[k]);
        end
    end

    always_comb begin
        logic [PW:0]  r1;
        logic [W+2:0] q1;
        for (int k = 0; k < 3; k++) begin
            r1 = {a_p_reg[k][PW-1], a_p_reg[k]} + (PW+1)'(HALF);
            q1 = r1[PW:F];
            a_b_next[k] = ctl_a_reg.accel_scale ? sat_w({q1[W+2], q1}) : a_a_reg[k];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ra_p_next[i][j] = PW'(row_c[i][j]) * PW'(a_b_reg[j]);
                rg_p_next[i][j] = PW'(row_c[i][j]) * PW'(g_b_reg[j]);
            end
        end
    end

    // Each row sums its three full products and rounds once.
    always_comb begin
        logic [SW-1:0] sum_a;
        logic [SW-1:0] sum_g;
        for (int i = 0; i < 3; i++) begin
            sum_a = SW'(ra_p_reg[i][0]) + SW'(ra_p_reg[i][1]) + SW'(ra_p_reg[i][2]) + HALF;
            sum_g = SW'(rg_p_reg[i][0]) + SW'(rg_p_reg[i][1]) + SW'(rg_p_reg[i][2]) + HALF;
            out_data_next[i*W +: W]     = ctl_c_reg.align ? sat_w(sum_a[SW-1:F]) : a_c_reg[i];
            out_data_next[(i+3)*W +: W] = ctl_c_reg.align ? sat_w(sum_g[SW-1:F]) : g_c_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg     <= 1'b0;
            vld_b_reg     <= 1'b0;
            vld_c_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_a_reg     <= q_valid;
            vld_b_reg     <= vld_a_reg;
            vld_c_reg     <= vld_b_reg;
            out_valid_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_a_reg    <= q_ctl;
            ctl_b_reg    <= ctl_a_reg;
            ctl_c_reg    <= ctl_b_reg;
            out_data_reg <= out_data_next;
            for (int k = 0; k < 3; k++) begin
                a_p_reg[k] <= a_p_next[k];
                a_a_reg[k] <= a_in[k];
                g_a_reg[k] <= g_in[k];
                a_b_reg[k] <= a_b_next[k];
                g_b_reg[k] <= g_a_reg[k];
                a_c_reg[k] <= a_b_reg[k];
                g_c_reg[k] <= g_b_reg[k];
                for (int j = 0; j < 3; j++) begin
                    ra_p_reg[k][j] <= ra_p_next[k][j];
                    rg_p_reg[k][j] <= rg_p_next[k][j];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/imu_sample_correction_core.sv -----
// An accepted word goes into the queue and then through back stages A to D to m_tvalid.
// Throughput: one word per cycle; the front end writes a four-entry queue that feeds
// a four-stage back pipeline (scale multiply, round, rotation multiply, row sum).
// Stalls on m_tready hold the pipeline; the queue keeps s_tready high until it is full.
// Reset (aresetn low, synchronous) empties queue and pipeline and loads the identity setup.
`timescale 1ns / 1ps
`default_nettype none

module imu_sample_correction_core import imusc_pkg::*; #(
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int IN_DW  = ((6 * SAMPLE_WIDTH + FLAG_W + 7) / 8) * 8,
    localparam int OUT_DW = ((6 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, enable_bits, zero fill
    input  logic [IN_DW-1:0]      s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_accel_x, out_accel_y, out_accel_z, out_gyro_x, out_gyro_y, out_gyro_z
    output logic [OUT_DW-1:0]     m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DW  = 6 * SAMPLE_WIDTH;
    localparam int QDW = CTL_W + DW;

    logic [CFG_DATA_W-1:0] accel_bias_reg;
    logic [CFG_DATA_W-1:0] accel_scale_reg;
    logic [CFG_DATA_W-1:0] gyro_offset_reg;
    logic [CFG_DATA_W-1:0] align_row0_reg;
    logic [CFG_DATA_W-1:0] align_row1_reg;
    logic [CFG_DATA_W-1:0] align_row2_reg;
    logic [FLAG_W-1:0]     valid_flags_reg;

    logic                  q_full;
    logic                  q_push;
    imusc_ctl_t            push_ctl;
    logic [DW-1:0]         push_data;
    logic                  q_valid;
    logic                  q_ready;
    logic [QDW-1:0]        q_rdata;
    imusc_ctl_t            pop_ctl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_bias_reg  <= RST_ACCEL_BIAS;
            accel_scale_reg <= RST_ACCEL_SCALE;
            gyro_offset_reg <= RST_GYRO_OFFSET;
            align_row0_reg  <= RST_ALIGN_ROW0;
            align_row1_reg  <= RST_ALIGN_ROW1;
            align_row2_reg  <= RST_ALIGN_ROW2;
            valid_flags_reg <= RST_VALID_FLAGS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ACCEL_BIAS:  accel_bias_reg  <= cfg_wdata;
                REG_ACCEL_SCALE: accel_scale_reg <= cfg_wdata;
                REG_GYRO_OFFSET: gyro_offset_reg <= cfg_wdata;
                REG_ALIGN_ROW0:  align_row0_reg  <= cfg_wdata;
                REG_ALIGN_ROW1:  align_row1_reg  <= cfg_wdata;
                REG_ALIGN_ROW2:  align_row2_reg  <= cfg_wdata;
                REG_VALID_FLAGS: valid_flags_reg <= cfg_wdata[FLAG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    imusc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .accel_bias  (accel_bias_reg),
        .gyro_offset (gyro_offset_reg),
        .valid_flags (valid_flags_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_ctl       (push_ctl),
        .q_data      (push_data)
    );

    imusc_queue #(
        .DATA_W (QDW),
        .DEPTH  (Q_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({push_ctl, push_data}),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_rdata)
    );

    assign pop_ctl = imusc_ctl_t'(q_rdata[DW +: CTL_W]);

    imusc_back #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_ctl       (pop_ctl),
        .q_data      (q_rdata[DW-1:0]),
        .accel_scale (accel_scale_reg),
        .align_row0  (align_row0_reg),
        .align_row1  (align_row1_reg),
        .align_row2  (align_row2_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/imusc_checker.sv -----
// Port-level checker of the sample correction core and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "imu_sample_correction_core_assert.svh"

module imusc_checker #(
    parameter int OUT_DW = 96
) (
    input wire              aclk,
    input wire              aresetn,
    input wire              s_tvalid,
    input wire              s_tready,
    input wire              m_tvalid,
    input wire              m_tready,
    input wire [OUT_DW-1:0] m_tdata
);

    `IMUSC_ASSERT_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "stalled output word dropped")
    `IMUSC_ASSERT_RST(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled output word changed")
    `IMUSC_ASSERT(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output word present right after reset")
    `IMUSC_ASSERT_RST(a_full_by_push, aclk, aresetn, $fell(s_tready) |-> $past(s_tvalid && s_tready), "queue filled up without an accepted word")

endmodule

bind imu_sample_correction_core imusc_checker #(.OUT_DW(OUT_DW)) u_imusc_checker (.*);

`default_nettype wire

// ----- test/imu_sample_correction_core_tb.sv -----
// Self-checking testbench for the IMU sample correction core.
`timescale 1ns / 1ps

module imu_sample_correction_core_tb;
    import imusc_pkg::*;

    localparam int S_DW = ((6 * SAMPLE_WIDTH_DEF + FLAG_W + 7) / 8) * 8;
    localparam int M_DW = ((6 * SAMPLE_WIDTH_DEF + 7) / 8) * 8;
    localparam int SW = SAMPLE_WIDTH_DEF;
    localparam int FB = COEF_FRAC_BITS_DEF;
    // Index 7 is not a register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 64;

    typedef logic signed [63:0] wide_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] accel_bias;
        logic [CFG_DATA_W-1:0] accel_scale;
        logic [CFG_DATA_W-1:0] gyro_offset;
        logic [CFG_DATA_W-1:0] row0;
        logic [CFG_DATA_W-1:0] row1;
        logic [CFG_DATA_W-1:0] row2;
        logic [FLAG_W-1:0]     flags;
    } imu_cfg_t;

    // Keeps its own copy of the registers and the corrected samples still owed.
    class imu_correction_checker;
        logic [CFG_DATA_W-1:0] accel_bias, accel_scale, gyro_offset;
        logic [CFG_DATA_W-1:0] align_row[3];
        logic [FLAG_W-1:0]     valid_flags;
        logic [M_DW-1:0]       corrected_q[$];
        int                    err_count;

        function new();
            accel_bias   = RST_ACCEL_BIAS;
            accel_scale  = RST_ACCEL_SCALE;
            gyro_offset  = RST_GYRO_OFFSET;
            align_row[0] = RST_ALIGN_ROW0;
            align_row[1] = RST_ALIGN_ROW1;
            align_row[2] = RST_ALIGN_ROW2;
            valid_flags  = RST_VALID_FLAGS;
            err_count    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ACCEL_BIAS:  accel_bias   = val;
                REG_ACCEL_SCALE: accel_scale  = val;
                REG_GYRO_OFFSET: gyro_offset  = val;
                REG_ALIGN_ROW0:  align_row[0] = val;
                REG_ALIGN_ROW1:  align_row[1] = val;
                REG_ALIGN_ROW2:  align_row[2] = val;
                REG_VALID_FLAGS: valid_flags  = val[FLAG_W-1:0];
                default: ;
            endcase
        endfunction

        function wide_t lane(logic [CFG_DATA_W-1:0] r, int k);
            wide_t v;
            v = wide_t'($signed(r[16*k +: 16]));
            return v;
        endfunction

        function wide_t sat_sample(wide_t v);
            wide_t hi;
            hi = (64'sd1 <<< (SW - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        // Round to nearest with ties toward plus infinity, then saturate.
        function wide_t round_fix(wide_t p);
            return sat_sample((p + (64'sd1 <<< (FB - 1))) >>> FB);
        endfunction

        function logic [M_DW-1:0] correct_sample(logic [S_DW-1:0] w);
            wide_t      a[3], g[3], ra[3], rg[3];
            imusc_ctl_t on;
            logic [M_DW-1:0] res;
            on = imusc_ctl_t'(w[6*SW +: FLAG_W] & valid_flags);
            for (int i = 0; i < 3; i++) begin
                a[i] = wide_t'($signed(w[SW*i +: SW]));
                g[i] = wide_t'($signed(w[SW*(3+i) +: SW]));
            end
            for (int i = 0; i < 3; i++) begin
                if (on.accel_bias) a[i] = sat_sample(a[i] - lane(accel_bias, i));
                if (on.accel_scale) a[i] = round_fix(a[i] * lane(accel_scale, i));
                if (on.gyro_offset) g[i] = sat_sample(g[i] - lane(gyro_offset, i));
            end
            // Each row works on the vector as it was before the rotation.
            for (int i = 0; i < 3; i++) begin
                ra[i] = '0;
                rg[i] = '0;
                for (int j = 0; j < 3; j++) begin
                    ra[i] += lane(align_row[i], j) * a[j];
                    rg[i] += lane(align_row[i], j) * g[j];
                end
            end
            if (on.align) begin
                for (int i = 0; i < 3; i++) begin
                    a[i] = round_fix(ra[i]);
                    g[i] = round_fix(rg[i]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                res[SW*i +: SW]     = a[i][SW-1:0];
                res[SW*(3+i) +: SW] = g[i][SW-1:0];
            end
            return res;
        endfunction

        function void note_sample(logic [S_DW-1:0] w);
            corrected_q.push_back(correct_sample(w));
        endfunction

        function int pending();
            return corrected_q.size();
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            err_count++;
        endtask

        task check_result(logic [M_DW-1:0] got);
            logic [M_DW-1:0] want;
            string names[6] = '{"out_accel_x", "out_accel_y", "out_accel_z",
                                "out_gyro_x", "out_gyro_y", "out_gyro_z"};
            if (corrected_q.size() == 0) begin
                report($sformatf("result %h arrived with nothing outstanding", got));
                return;
            end
            want = corrected_q.pop_front();
            for (int k = 0; k < 6; k++) begin
                if (got[SW*k +: SW] !== want[SW*k +: SW])
                    report($sformatf("%s: got %0d, expected %0d", names[k],
                                     $signed(got[SW*k +: SW]), $signed(want[SW*k +: SW])));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DW-1:0]       s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DW-1:0]       m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_ACCEL_BIAS;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    imu_correction_checker sb = new();
    bit idle_on = 1'b1;
    bit hold_rx_req = 1'b0;
    int stall_cycles = 0;

    imu_sample_correction_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Everything here reads values from before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_sample(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (cfg_wr_en) sb.write_reg(cfg_index, cfg_wdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("imu_sample_correction_core: mismatch");
            $finish;
        end
    end

    // Result side: random back-pressure while idle_on is set, plus one long hold on request.
    initial begin
        int stall;
        int r;
        stall = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_rx_req) begin
                hold_rx_req = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else if (!idle_on) begin
                m_tready <= 1'b1;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                end
            end
        end
    end

    function automatic logic [S_DW-1:0] pack_sample(
        int ax, int ay, int az, int gx, int gy, int gz, logic [FLAG_W-1:0] en);
        logic [S_DW-1:0] w;
        w = '0;
        w[6*SW+FLAG_W-1:0] = {en, SW'(gz), SW'(gy), SW'(gx), SW'(az), SW'(ay), SW'(ax)};
        return w;
    endfunction

    function automatic logic [SW-1:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 7))
            0: return 16'h4000;
            1: return 16'hC000;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return 16'($signed($urandom_range(0, 1024)) - 512);
            5: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic imu_cfg_t rand_cfg();
        imu_cfg_t c;
        c.accel_bias  = {rand_axis(), rand_axis(), rand_axis()};
        c.accel_scale = {rand_coef(), rand_coef(), rand_coef()};
        c.gyro_offset = {rand_axis(), rand_axis(), rand_axis()};
        // A matrix near the identity, with the last axis flipped, keeps many results out of saturation.
        if ($urandom_range(0, 2) == 0) begin
            c.row0 = {16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)), 16'h4000};
            c.row1 = {16'($urandom_range(0, 255)), 16'h3F00, 16'($urandom_range(0, 255))};
            c.row2 = {16'hC100, 16'($urandom_range(0, 255)), 16'($urandom_range(0, 255))};
        end else begin
            c.row0 = {rand_coef(), rand_coef(), rand_coef()};
            c.row1 = {rand_coef(), rand_coef(), rand_coef()};
            c.row2 = {rand_coef(), rand_coef(), rand_coef()};
        end
        c.flags = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'hF;
        return c;
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(imu_cfg_t c);
        logic [CFG_DATA_W-1:0] v;
        cfg_write(REG_ACCEL_BIAS, c.accel_bias);
        cfg_write(REG_ACCEL_SCALE, c.accel_scale);
        cfg_write(REG_GYRO_OFFSET, c.gyro_offset);
        cfg_write(REG_ALIGN_ROW0, c.row0);
        cfg_write(REG_ALIGN_ROW1, c.row1);
        cfg_write(REG_ALIGN_ROW2, c.row2);
        // Upper bits of the flag write carry junk that must be dropped.
        v = CFG_DATA_W'({$urandom, $urandom});
        v[FLAG_W-1:0] = c.flags;
        cfg_write(REG_VALID_FLAGS, v);
        cfg_write(REG_UNMAPPED, CFG_DATA_W'({$urandom, $urandom}));
    endtask

    task automatic send_sample(logic [S_DW-1:0] w);
        int gap;
        int r;
        gap = 0;
        if (idle_on) begin
            r = $urandom_range(0, 99);
            if (r >= 90) gap = $urandom_range(8, 25);
            else if (r >= 55) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering words and wait for every owed result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [S_DW-1:0] rand_sample();
        logic [FLAG_W-1:0] en;
        en = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom);
        return pack_sample(int'($signed(rand_axis())), int'($signed(rand_axis())),
                           int'($signed(rand_axis())), int'($signed(rand_axis())),
                           int'($signed(rand_axis())), int'($signed(rand_axis())), en);
    endfunction

    initial begin
        imu_cfg_t c;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setup has every valid flag clear, so samples pass through.
        send_sample(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768, 4'hF));
        send_sample(pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 4'hF));
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 4'h0));
        drain();

        // Biases that saturate, scales at 0.5, near +2 and -2, and an axis swap
        // with a sign flip so that a partly rotated vector would show.
        c.accel_bias  = {16'h0001, 16'h8000, 16'h7FFF};
        c.accel_scale = {16'h8000, 16'h7FFF, 16'h2000};
        c.gyro_offset = {16'h0000, 16'h7FFF, 16'h8000};
        c.row0        = {16'h0000, 16'h4000, 16'h0000};
        c.row1        = {16'h0000, 16'h0000, 16'h4000};
        c.row2        = {16'hC000, 16'h0000, 16'h0000};
        c.flags       = 4'hF;
        apply_cfg(c);
        send_sample(pack_sample(-32768, 32767, -32768, 32767, -32768, 32767, 4'hF));
        send_sample(pack_sample(32767, -32768, 32767, -32768, 32767, -32768, 4'hF));
        send_sample(pack_sample(0, 0, 0, 0, 0, 0, 4'hF));
        for (int en = 0; en < 16; en++)
            send_sample(pack_sample(1000, -2000, 3000, -4000, 5000, -6000, 4'(en)));
        drain();

        // Rounding ties: 0.5, 1.5 and -0.5 go up, -0.5 of a negative goes to zero.
        c.accel_bias  = '0;
        c.accel_scale = {16'hE000, 16'h6000, 16'h2000};
        c.gyro_offset = '0;
        c.row0        = RST_ALIGN_ROW0;
        c.row1        = RST_ALIGN_ROW1;
        c.row2        = RST_ALIGN_ROW2;
        c.flags       = 4'hB;
        apply_cfg(c);
        send_sample(pack_sample(1, 1, 1, 7, 7, 7, 4'hF));
        send_sample(pack_sample(-1, -1, -1, -7, -7, -7, 4'hF));
        send_sample(pack_sample(3, -3, 5, 0, 0, 0, 4'hF));
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                c = '{default: '0};
                c.accel_bias  = {3{16'h7FFF}};
                c.accel_scale = {3{16'h7FFF}};
                c.gyro_offset = {3{16'h7FFF}};
                c.row0 = {3{16'h7FFF}};
                c.row1 = {3{16'h7FFF}};
                c.row2 = {3{16'h7FFF}};
                c.flags = 4'hF;
            end else if (ph == 1) begin
                c.accel_bias  = {3{16'h8000}};
                c.accel_scale = {3{16'h8000}};
                c.gyro_offset = {3{16'h8000}};
                c.row0 = {3{16'h8000}};
                c.row1 = {3{16'h8000}};
                c.row2 = {3{16'h8000}};
                c.flags = 4'hF;
            end else begin
                c = rand_cfg();
            end
            apply_cfg(c);
            idle_on = (ph != 4);
            // Long receiver hold while words keep coming fills the queue.
            if (ph == 2) hold_rx_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == PHASE_ITEMS / 2) drain();
                send_sample(rand_sample());
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.report($sformatf("%0d corrected samples never arrived", sb.pending()));
        if (sb.err_count == 0)
            $display("imu_sample_correction_core: match");
        else
            $display("imu_sample_correction_core: mismatch");
        $finish;
    end

endmodule
